// ===== src/lmtr_pkg.sv =====
// Shared constants and codes of the peak and rms level meter.
package lmtr_pkg;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	localparam logic [0:0] REG_ATTACK  = 1'b0;
	localparam logic [0:0] REG_RELEASE = 1'b1;

	localparam int unsigned QDEPTH = 4;

	localparam logic [15:0] CLIP_THRESHOLD = 16'd32760;
	localparam logic [16:0] COEF_ONE       = 17'h10000;
	localparam logic [15:0] DB_FLOOR_MAG   = 16'd24576;
	localparam logic [18:0] DB_PER_OCTAVE  = 19'd394566;
	localparam logic [19:0] LOG2_FULL      = 20'hF0000;
	localparam logic [39:0] DB_ROUND       = 40'h800000;

endpackage

// ===== src/lmtr_front.sv =====
// Front end: takes samples, keeps the per-block statistics and posts closed blocks and clears.
module lmtr_front #(
	parameter int unsigned MAX_BLOCK_SAMPLES = 4096,
	parameter int unsigned CW = 13,
	parameter int unsigned SW = 44
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic                op,
	input  logic signed [15:0]  sample,
	input  logic                last_of_block,
	output logic                rec_push,
	output logic                rec_clear,
	output logic [15:0]         rec_peak,
	output logic [SW-1:0]       rec_sum,
	output logic [CW-1:0]       rec_count,
	output logic [CW-1:0]       rec_clips
);

	logic               vld_s1;
	logic               op_s1;
	logic               last_s1;
	logic [15:0]        mag_s1;
	logic [30:0]        sq_s1;
	logic               clip_s1;

	logic [15:0]        peak_q;
	logic [SW-1:0]      sum_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      clips_q;

	logic [15:0]        mag;
	logic signed [31:0] sq_full;
	logic               is_sample;
	logic               close;

	assign mag     = sample[15] ? 16'(~sample + 16'sd1) : 16'(sample);
	assign sq_full = sample * sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1   <= op;
			last_s1 <= last_of_block;
			mag_s1  <= mag;
			sq_s1   <= sq_full[30:0];
			clip_s1 <= (mag >= lmtr_pkg::CLIP_THRESHOLD);
		end
	end

	assign is_sample = vld_s1 && (op_s1 == lmtr_pkg::OP_SAMPLE);
	assign rec_peak  = (mag_s1 > peak_q) ? mag_s1 : peak_q;
	assign rec_sum   = sum_q + SW'(sq_s1);
	assign rec_count = cnt_q + CW'(1);
	assign rec_clips = clips_q + CW'(clip_s1);
	assign close     = is_sample && (last_s1 || (rec_count == CW'(MAX_BLOCK_SAMPLES)));
	assign rec_clear = (op_s1 == lmtr_pkg::OP_CLEAR);
	assign rec_push  = vld_s1 && (rec_clear || close);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q  <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
			clips_q <= '0;
		end else if (is_sample) begin
			if (close) begin
				peak_q  <= '0;
				sum_q   <= '0;
				cnt_q   <= '0;
				clips_q <= '0;
			end else begin
				peak_q  <= rec_peak;
				sum_q   <= rec_sum;
				cnt_q   <= rec_count;
				clips_q <= rec_clips;
			end
		end
	end

endmodule

// ===== src/lmtr_fifo.sv =====
// Short queue of block records between the front end and the back end.
module lmtr_fifo #(
	parameter int unsigned W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty,
	output logic         nearly_full
);

	localparam int unsigned PW = $clog2(lmtr_pkg::QDEPTH);

	logic [W-1:0] mem_q [lmtr_pkg::QDEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   lvl_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			lvl_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + PW'(1);
			end
			if (push && !pop) begin
				lvl_q <= lvl_q + (PW+1)'(1);
			end else if (pop && !push) begin
				lvl_q <= lvl_q - (PW+1)'(1);
			end
		end
	end

	assign rdata       = mem_q[rp_q];
	assign empty       = (lvl_q == '0);
	assign nearly_full = (lvl_q >= (PW+1)'(lmtr_pkg::QDEPTH - 1));

endmodule

// ===== src/lmtr_back.sv =====
// Back end: mean, square root, smoothing, dB conversion and the result register.
module lmtr_back #(
	parameter int unsigned CW = 13,
	parameter int unsigned SW = 44
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [0:0]         wr_index,
	input  logic [16:0]        wr_data,
	input  logic               q_empty,
	output logic               q_pop,
	input  logic               rec_clear,
	input  logic [15:0]        rec_peak,
	input  logic [SW-1:0]      rec_sum,
	input  logic [CW-1:0]      rec_count,
	input  logic [CW-1:0]      rec_clips,
	input  logic               pop,
	output logic               empty,
	output logic [15:0]        smoothed_peak,
	output logic [15:0]        smoothed_rms,
	output logic signed [15:0] peak_decibels,
	output logic signed [15:0] rms_decibels,
	output logic               clipping,
	output logic [12:0]        block_clip_count,
	output logic [15:0]        peak_hold,
	output logic [31:0]        clip_total
);

	localparam int unsigned STPW = $clog2(SW + 1);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_DIV  = 9'b000000010,
		ST_SQRT = 9'b000000100,
		ST_SMTH = 9'b000001000,
		ST_DBI  = 9'b000010000,
		ST_DBS  = 9'b000100000,
		ST_DBM  = 9'b001000000,
		ST_DBF  = 9'b010000000,
		ST_EMIT = 9'b100000000
	} state_t;

	state_t            state_q;
	logic [16:0]       att_q;
	logic [16:0]       rel_q;
	logic [15:0]       pk_lvl_q;
	logic [15:0]       rms_lvl_q;
	logic [15:0]       hold_q;
	logic [31:0]       acc_q;
	logic [15:0]       blk_peak_q;
	logic [CW-1:0]     blk_clips_q;
	logic [CW-1:0]     div_cnt_q;
	logic [CW-1:0]     rem_q;
	logic [SW-1:0]     quo_q;
	logic [STPW-1:0]   stp_q;
	logic [17:0]       sq_rem_q;
	logic [15:0]       root_q;
	logic [2:0]        ph_q;
	logic [32:0]       prod_a_q;
	logic [32:0]       prod_b_q;
	logic              db_rms_q;
	logic [3:0]        dbe_q;
	logic [30:0]       dbx_q;
	logic [15:0]       frac_q;
	logic [38:0]       dbp_q;
	logic [15:0]       pk_db_q;
	logic [15:0]       rms_db_q;
	logic              o_valid_q;

	logic [CW:0]       trial;
	logic              div_ge;
	logic [19:0]       sq_cur;
	logic [19:0]       sq_trial;
	logic              sq_ge;
	logic              sel_rms;
	logic [15:0]       sm_old;
	logic [15:0]       sm_lvl;
	logic [16:0]       c_raw;
	logic [16:0]       c_sat;
	logic [32:0]       mul_a;
	logic [32:0]       mul_b;
	logic [33:0]       sm_sum;
	logic [15:0]       sm_new;
	logic [32:0]       clip_sum;
	logic [15:0]       db_v;
	logic [3:0]        db_e;
	logic [30:0]       db_x;
	logic [61:0]       db_sq;
	logic [31:0]       db_t;
	logic [19:0]       db_m;
	logic [39:0]       db_r;
	logic [15:0]       db_p;
	logic [15:0]       db_cap;
	logic [15:0]       db_out;
	logic              load;

	assign trial  = {rem_q, quo_q[SW-1]};
	assign div_ge = (trial >= {1'b0, div_cnt_q});

	assign sq_cur   = {sq_rem_q, quo_q[31:30]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_ge    = (sq_cur >= sq_trial);

	assign sel_rms = (ph_q >= 3'd3);
	assign sm_old  = sel_rms ? rms_lvl_q : pk_lvl_q;
	assign sm_lvl  = sel_rms ? root_q : blk_peak_q;
	assign c_raw   = (sm_lvl > sm_old) ? att_q : rel_q;
	assign c_sat   = (c_raw > lmtr_pkg::COEF_ONE) ? lmtr_pkg::COEF_ONE : c_raw;
	assign mul_a   = {17'b0, sm_old} * {16'b0, 17'(lmtr_pkg::COEF_ONE - c_sat)};
	assign mul_b   = {17'b0, sm_lvl} * {16'b0, c_sat};
	assign sm_sum  = {1'b0, prod_a_q} + {1'b0, prod_b_q} + 34'd32768;
	assign sm_new  = sm_sum[31:16];

	assign clip_sum = {1'b0, acc_q} + 33'(blk_clips_q);

	assign db_v = db_rms_q ? rms_lvl_q : pk_lvl_q;

	always_comb begin
		db_e = '0;
		for (int i = 0; i < 16; i++) begin
			if (db_v[i]) begin
				db_e = 4'(i);
			end
		end
	end

	assign db_x   = 31'({15'b0, db_v} << (5'd30 - {1'b0, db_e}));
	assign db_sq  = {31'b0, dbx_q} * {31'b0, dbx_q};
	assign db_t   = db_sq[61:30];
	assign db_m   = lmtr_pkg::LOG2_FULL - {dbe_q, frac_q};
	assign db_r   = {1'b0, dbp_q} + lmtr_pkg::DB_ROUND;
	assign db_p   = db_r[39:24];
	assign db_cap = (db_p > lmtr_pkg::DB_FLOOR_MAG) ? lmtr_pkg::DB_FLOOR_MAG : db_p;
	assign db_out = 16'(~db_cap + 16'd1);

	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign load  = (state_q == ST_EMIT) && (!o_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q <= lmtr_pkg::COEF_ONE;
			rel_q <= lmtr_pkg::COEF_ONE;
		end else if (wr_en) begin
			unique case (wr_index)
				lmtr_pkg::REG_ATTACK:  att_q <= wr_data;
				lmtr_pkg::REG_RELEASE: rel_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pk_lvl_q  <= '0;
			rms_lvl_q <= '0;
			hold_q    <= '0;
			acc_q     <= '0;
			stp_q     <= '0;
			ph_q      <= '0;
			db_rms_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (rec_clear) begin
							pk_lvl_q  <= '0;
							rms_lvl_q <= '0;
							hold_q    <= '0;
							acc_q     <= '0;
						end else begin
							stp_q   <= STPW'(SW);
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					stp_q <= stp_q - STPW'(1);
					if (stp_q == STPW'(1)) begin
						stp_q   <= STPW'(16);
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					stp_q <= stp_q - STPW'(1);
					if (stp_q == STPW'(1)) begin
						ph_q    <= '0;
						state_q <= ST_SMTH;
					end
				end
				ST_SMTH: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd2) begin
						pk_lvl_q <= sm_new;
					end
					if (ph_q == 3'd5) begin
						rms_lvl_q <= sm_new;
						hold_q    <= (blk_peak_q > hold_q) ? blk_peak_q : hold_q;
						acc_q     <= clip_sum[32] ? '1 : clip_sum[31:0];
						db_rms_q  <= 1'b0;
						state_q   <= ST_DBI;
					end
				end
				ST_DBI: begin
					if (db_v == '0) begin
						db_rms_q <= 1'b1;
						state_q  <= db_rms_q ? ST_EMIT : ST_DBI;
					end else begin
						stp_q   <= STPW'(16);
						state_q <= ST_DBS;
					end
				end
				ST_DBS: begin
					stp_q <= stp_q - STPW'(1);
					if (stp_q == STPW'(1)) begin
						state_q <= ST_DBM;
					end
				end
				ST_DBM: begin
					state_q <= ST_DBF;
				end
				ST_DBF: begin
					db_rms_q <= 1'b1;
					state_q  <= db_rms_q ? ST_EMIT : ST_DBI;
				end
				ST_EMIT: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			blk_peak_q  <= rec_peak;
			blk_clips_q <= rec_clips;
			div_cnt_q   <= rec_count;
			rem_q       <= '0;
			quo_q       <= rec_sum;
		end
		if (state_q == ST_DIV) begin
			rem_q <= div_ge ? CW'(trial - {1'b0, div_cnt_q}) : trial[CW-1:0];
			quo_q <= {quo_q[SW-2:0], div_ge};
			if (stp_q == STPW'(1)) begin
				sq_rem_q <= '0;
				root_q   <= '0;
			end
		end
		if (state_q == ST_SQRT) begin
			sq_rem_q <= sq_ge ? 18'(sq_cur - sq_trial) : sq_cur[17:0];
			root_q   <= {root_q[14:0], sq_ge};
			quo_q    <= quo_q << 2;
		end
		if (state_q == ST_SMTH) begin
			if (ph_q == 3'd0 || ph_q == 3'd3) begin
				prod_a_q <= mul_a;
			end
			if (ph_q == 3'd1 || ph_q == 3'd4) begin
				prod_b_q <= mul_b;
			end
		end
		if (state_q == ST_DBI) begin
			dbe_q  <= db_e;
			dbx_q  <= db_x;
			frac_q <= '0;
			if (db_v == '0) begin
				if (db_rms_q) begin
					rms_db_q <= 16'(~lmtr_pkg::DB_FLOOR_MAG + 16'd1);
				end else begin
					pk_db_q <= 16'(~lmtr_pkg::DB_FLOOR_MAG + 16'd1);
				end
			end
		end
		if (state_q == ST_DBS) begin
			dbx_q  <= db_t[31] ? db_t[31:1] : db_t[30:0];
			frac_q <= {frac_q[14:0], db_t[31]};
		end
		if (state_q == ST_DBM) begin
			dbp_q <= {19'b0, db_m} * {20'b0, lmtr_pkg::DB_PER_OCTAVE};
		end
		if (state_q == ST_DBF) begin
			if (db_rms_q) begin
				rms_db_q <= db_out;
			end else begin
				pk_db_q <= db_out;
			end
		end
		if (load) begin
			smoothed_peak    <= pk_lvl_q;
			smoothed_rms     <= rms_lvl_q;
			peak_decibels    <= pk_db_q;
			rms_decibels     <= rms_db_q;
			clipping         <= (blk_clips_q != '0);
			block_clip_count <= 13'(blk_clips_q);
			peak_hold        <= hold_q;
			clip_total       <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (load) begin
			o_valid_q <= 1'b1;
		end else if (pop) begin
			o_valid_q <= 1'b0;
		end
	end

	assign empty = !o_valid_q;

endmodule

// ===== src/block_peak_rms_level_meter.sv =====
// Top level of the block peak and rms level meter.
// The front end takes one sample beat in every clock cycle while full is low and keeps the
// running peak, sum of squares, count and clip count of the open block. Each closed block, and
// each clear, goes through a four-entry queue to the back end, which works on one block at a
// time: a restoring divider of the SW-bit sum of squares by the count (SW = 31 plus the count
// width, 44 at the default block length), a bit-serial square root, smoothing of peak and rms
// and two logarithms for the dB levels. Full rises once the queue holds three records. A clear
// only resets the levels, the peak hold and the clip total and needs no arithmetic. A finished
// result waits in the output register while the next block is already being worked on.
module block_peak_rms_level_meter #(
	parameter int unsigned MAX_BLOCK_SAMPLES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               op,
	input  logic signed [15:0] sample,
	input  logic               last_of_block,
	output logic               empty,
	input  logic               pop,
	output logic [15:0]        smoothed_peak,
	output logic [15:0]        smoothed_rms,
	output logic signed [15:0] peak_decibels,
	output logic signed [15:0] rms_decibels,
	output logic               clipping,
	output logic [12:0]        block_clip_count,
	output logic [15:0]        peak_hold,
	output logic [31:0]        clip_total,
	input  logic               wr_en,
	input  logic [0:0]         wr_index,
	input  logic [16:0]        wr_data
);

	localparam int unsigned CW = $clog2(MAX_BLOCK_SAMPLES + 1);
	localparam int unsigned SW = 31 + CW;
	localparam int unsigned RW = 1 + 16 + SW + 2 * CW;

	logic          take;
	logic          rec_push;
	logic          rec_clear;
	logic [15:0]   rec_peak;
	logic [SW-1:0] rec_sum;
	logic [CW-1:0] rec_count;
	logic [CW-1:0] rec_clips;
	logic [RW-1:0] q_rdata;
	logic          q_empty;
	logic          q_pop;
	logic          q_nearly_full;

	assign full = q_nearly_full;
	assign take = push && !full;

	lmtr_front #(
		.MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES),
		.CW(CW),
		.SW(SW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.op(op),
		.sample(sample),
		.last_of_block(last_of_block),
		.rec_push(rec_push),
		.rec_clear(rec_clear),
		.rec_peak(rec_peak),
		.rec_sum(rec_sum),
		.rec_count(rec_count),
		.rec_clips(rec_clips)
	);

	lmtr_fifo #(
		.W(RW)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(rec_push),
		.wdata({rec_clear, rec_peak, rec_sum, rec_count, rec_clips}),
		.pop(q_pop),
		.rdata(q_rdata),
		.empty(q_empty),
		.nearly_full(q_nearly_full)
	);

	lmtr_back #(
		.CW(CW),
		.SW(SW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.rec_clear(q_rdata[RW-1]),
		.rec_peak(q_rdata[RW-2 -: 16]),
		.rec_sum(q_rdata[2*CW +: SW]),
		.rec_count(q_rdata[CW +: CW]),
		.rec_clips(q_rdata[CW-1:0]),
		.pop(pop),
		.empty(empty),
		.smoothed_peak(smoothed_peak),
		.smoothed_rms(smoothed_rms),
		.peak_decibels(peak_decibels),
		.rms_decibels(rms_decibels),
		.clipping(clipping),
		.block_clip_count(block_clip_count),
		.peak_hold(peak_hold),
		.clip_total(clip_total)
	);

endmodule

// ===== src/lmtr_checker.sv =====
// Port checker of the level meter and its binding to the top level.
module lmtr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic [15:0]        smoothed_peak,
	input logic signed [15:0] peak_decibels,
	input logic signed [15:0] rms_decibels,
	input logic [15:0]        peak_hold
);

	// A result beat that is not taken stays on the ports unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(smoothed_peak) && $stable(peak_decibels))
		else $error("result beat changed while waiting");

	// A silent smoothed peak reads as the dB floor.
	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && smoothed_peak == 16'd0 |-> peak_decibels == -16'sd24576)
		else $error("zero peak not at the dB floor");

	// Smoothing never carries the peak above the hold value.
	a_below_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> smoothed_peak <= peak_hold)
		else $error("smoothed peak above peak hold");

	// Levels in dB stay between the floor and full scale.
	a_db_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> rms_decibels <= 16'sd0 && rms_decibels >= -16'sd24576
			&& peak_decibels <= 16'sd0 && peak_decibels >= -16'sd24576)
		else $error("dB level out of range");

endmodule

bind block_peak_rms_level_meter lmtr_checker u_lmtr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.empty(empty),
	.pop(pop),
	.smoothed_peak(smoothed_peak),
	.peak_decibels(peak_decibels),
	.rms_decibels(rms_decibels),
	.peak_hold(peak_hold)
);
